// File: rtl/irpdt_pkg.sv
`default_nettype none

package irpdt_pkg;

    // Bits sent per message, and the width of the loaded code word
    localparam int MESSAGE_BITS_DEFAULT = 16;
    localparam int MSG_WIDTH            = 16;

    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 16;

    localparam logic [7:0]  CARRIER_HALF_RST = 8'd13;
    localparam logic [9:0]  ONE_MARK_RST     = 10'd61;
    localparam logic [9:0]  ZERO_MARK_RST    = 10'd30;
    localparam logic [15:0] ONE_SPACE_RST    = 16'd800;
    localparam logic [15:0] ZERO_SPACE_RST   = 16'd1600;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_CARRIER_HALF = 3'd0,
        CFG_ONE_MARK     = 3'd1,
        CFG_ZERO_MARK    = 3'd2,
        CFG_ONE_SPACE    = 3'd3,
        CFG_ZERO_SPACE   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  carrier_half;
        logic [9:0]  one_mark;
        logic [9:0]  zero_mark;
        logic [15:0] one_space;
        logic [15:0] zero_space;
    } t_cfg;

    // Timing loaded when a bit phase is entered
    typedef struct packed {
        logic        in_space;
        logic [9:0]  periods;
        logic [15:0] space;
    } t_phase;

endpackage

`default_nettype wire

// File: rtl/ir_pulse_distance_transmitter.sv
`default_nettype none

// Pulse distance IR sender: every transfer on the input channel is either a start (loads a
// code word, sent from bit 15 downwards) or one microsecond tick, and yields exactly one
// result giving the LED level for that tick, whether a message is still going and whether
// this tick ended it. One item is taken every clock cycle unless a result waits on i_out_ready;
// a result is offered once its item has passed the input register, then the result register;
// each item updates the bit timing counters and finds the next non-empty bit phase in the same
// cycle. Starts that arrive while a message is going are dropped. Configuration is written by the
// user through i_cfg_we / i_cfg_idx / i_cfg_data only while no item is in flight; it is not enforced.
module ir_pulse_distance_transmitter #(
    parameter int MESSAGE_BITS = irpdt_pkg::MESSAGE_BITS_DEFAULT
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [irpdt_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  wire logic [irpdt_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_op,
    input  wire logic [irpdt_pkg::MSG_WIDTH-1:0]      i_message,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic                                      o_led_on,
    output logic                                      o_busy_res,
    output logic                                      o_finished
);

    localparam int IDX_W = (MESSAGE_BITS > 1) ? $clog2(MESSAGE_BITS) : 1;

    irpdt_pkg::t_cfg r_cfg;

    logic                               r_in_valid;
    logic                               r_in_op;
    logic [irpdt_pkg::MSG_WIDTH-1:0]    r_in_message;

    logic [MESSAGE_BITS-1:0] r_word,     n_word;
    logic [IDX_W-1:0]        r_idx,      n_idx;
    logic                    r_in_space, n_in_space;
    logic [9:0]              r_periods,  n_periods;
    logic [7:0]              r_half_cnt, n_half_cnt;
    logic                    r_level,    n_level;
    logic [15:0]             r_space,    n_space;
    logic                    r_sending,  n_sending;

    logic                    r_out_valid;
    logic                    r_out_led;
    logic                    r_out_busy;
    logic                    r_out_fin;

    logic                    advance;
    logic                    start_go;
    logic [MESSAGE_BITS-1:0] word_new;
    logic [MESSAGE_BITS-1:0] settle_word;
    logic [IDX_W:0]          settle_from;
    logic                    settle_found;
    logic [IDX_W-1:0]        settle_idx;
    irpdt_pkg::t_phase       settle_phase;
    logic [7:0]              half;
    logic [7:0]              half_cnt_inc;
    logic [9:0]              periods_dec;
    logic [15:0]             space_dec;
    logic [15:0]             space_sel;
    logic                    enter;
    logic                    led;
    logic                    fin;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.carrier_half <= irpdt_pkg::CARRIER_HALF_RST;
            r_cfg.one_mark     <= irpdt_pkg::ONE_MARK_RST;
            r_cfg.zero_mark    <= irpdt_pkg::ZERO_MARK_RST;
            r_cfg.one_space    <= irpdt_pkg::ONE_SPACE_RST;
            r_cfg.zero_space   <= irpdt_pkg::ZERO_SPACE_RST;
        end else if (i_cfg_we) begin
            unique case (irpdt_pkg::t_cfg_idx'(i_cfg_idx))
                irpdt_pkg::CFG_CARRIER_HALF: r_cfg.carrier_half <= i_cfg_data[7:0];
                irpdt_pkg::CFG_ONE_MARK:     r_cfg.one_mark     <= i_cfg_data[9:0];
                irpdt_pkg::CFG_ZERO_MARK:    r_cfg.zero_mark    <= i_cfg_data[9:0];
                irpdt_pkg::CFG_ONE_SPACE:    r_cfg.one_space    <= i_cfg_data;
                irpdt_pkg::CFG_ZERO_SPACE:   r_cfg.zero_space   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op      <= i_op;
            r_in_message <= i_message;
        end
    end

    // ---------------- phase search ----------------
    // Word held in send order: entry k is the k-th bit to go out, zeros past the code word
    always_comb begin
        word_new = '0;
        for (int k = 0; k < MESSAGE_BITS; k++) begin
            if (k < irpdt_pkg::MSG_WIDTH) begin
                word_new[k] = r_in_message[irpdt_pkg::MSG_WIDTH-1-k];
            end
        end
    end

    assign start_go    = r_in_op && !r_sending;
    assign settle_word = start_go ? word_new : r_word;
    assign settle_from = start_go ? '0 : ({1'b0, r_idx} + (IDX_W+1)'(1));

    irpdt_settle #(
        .MESSAGE_BITS (MESSAGE_BITS)
    ) u_settle (
        .i_word  (settle_word),
        .i_from  (settle_from),
        .i_cfg   (r_cfg),
        .o_found (settle_found),
        .o_idx   (settle_idx),
        .o_phase (settle_phase)
    );

    // ---------------- tick processing ----------------
    assign half         = (r_cfg.carrier_half == '0) ? 8'd1 : r_cfg.carrier_half;
    assign half_cnt_inc = r_half_cnt + 8'd1;
    assign periods_dec  = r_periods - 10'd1;
    assign space_dec    = r_space - 16'd1;
    assign space_sel    = r_word[r_idx] ? r_cfg.one_space : r_cfg.zero_space;

    always_comb begin
        n_word     = r_word;
        n_idx      = r_idx;
        n_in_space = r_in_space;
        n_periods  = r_periods;
        n_half_cnt = r_half_cnt;
        n_level    = r_level;
        n_space    = r_space;
        n_sending  = r_sending;
        enter      = 1'b0;
        led        = 1'b0;
        fin        = 1'b0;

        if (advance) begin
            if (r_in_op) begin
                if (!r_sending) begin
                    n_word    = word_new;
                    n_sending = 1'b1;
                    enter     = 1'b1;
                end
            end else if (r_sending) begin
                if (r_in_space) begin
                    n_space = space_dec;
                    if (space_dec == '0) begin
                        enter = 1'b1;
                    end
                end else begin
                    led = r_level;
                    if (half_cnt_inc >= half) begin
                        n_half_cnt = '0;
                        if (r_level) begin
                            n_level = 1'b0;
                        end else begin
                            n_level   = 1'b1;
                            n_periods = periods_dec;
                            // end of the mark: drop to the space, or skip an empty one
                            if (periods_dec == '0) begin
                                n_level = 1'b0;
                                if (space_sel != '0) begin
                                    n_in_space = 1'b1;
                                    n_space    = space_sel;
                                end else begin
                                    enter = 1'b1;
                                end
                            end
                        end
                    end else begin
                        n_half_cnt = half_cnt_inc;
                    end
                end
            end

            if (enter) begin
                if (settle_found) begin
                    n_idx      = settle_idx;
                    n_in_space = settle_phase.in_space;
                    if (settle_phase.in_space) begin
                        n_space = settle_phase.space;
                    end else begin
                        n_periods  = settle_phase.periods;
                        n_half_cnt = '0;
                        n_level    = 1'b1;
                    end
                end else begin
                    n_sending  = 1'b0;
                    n_in_space = 1'b0;
                    n_periods  = '0;
                    n_half_cnt = '0;
                    n_level    = 1'b0;
                    n_space    = '0;
                    fin        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word     <= '0;
            r_idx      <= '0;
            r_in_space <= 1'b0;
            r_periods  <= '0;
            r_half_cnt <= '0;
            r_level    <= 1'b0;
            r_space    <= '0;
            r_sending  <= 1'b0;
        end else begin
            r_word     <= n_word;
            r_idx      <= n_idx;
            r_in_space <= n_in_space;
            r_periods  <= n_periods;
            r_half_cnt <= n_half_cnt;
            r_level    <= n_level;
            r_space    <= n_space;
            r_sending  <= n_sending;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_led  <= led;
            r_out_busy <= n_sending;
            r_out_fin  <= fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_on    = r_out_led;
    assign o_busy_res  = r_out_busy;
    assign o_finished  = r_out_fin;

    // ---------------- assertions ----------------
    a_fin_not_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_finished) |-> !o_busy_res)
        else $error("finished reported while still busy");

    a_led_only_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_led_on) |-> o_busy_res)
        else $error("LED driven on a tick that left the sender idle");

    a_idle_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (!r_in_space && !r_level))
        else $error("phase state left over while idle");

endmodule

`default_nettype wire

// File: rtl/irpdt_settle.sv
`default_nettype none

// Finds the first bit at or after i_from whose mark or space is not empty,
// and gives the phase that bit starts with.
module irpdt_settle #(
    parameter  int MESSAGE_BITS = irpdt_pkg::MESSAGE_BITS_DEFAULT,
    localparam int IDX_W        = (MESSAGE_BITS > 1) ? $clog2(MESSAGE_BITS) : 1
) (
    input  wire logic [MESSAGE_BITS-1:0] i_word,
    input  wire logic [IDX_W:0]          i_from,
    input  wire irpdt_pkg::t_cfg         i_cfg,
    output logic                         o_found,
    output logic [IDX_W-1:0]             o_idx,
    output irpdt_pkg::t_phase            o_phase
);

    logic                    empty_one;
    logic                    empty_zero;
    logic [MESSAGE_BITS-1:0] cand;
    logic [IDX_W-1:0]        pos;
    logic                    cur_bit;
    logic [9:0]              marks;

    assign empty_one  = (i_cfg.one_mark == '0) && (i_cfg.one_space == '0);
    assign empty_zero = (i_cfg.zero_mark == '0) && (i_cfg.zero_space == '0);

    always_comb begin
        for (int k = 0; k < MESSAGE_BITS; k++) begin
            cand[k] = ((IDX_W+1)'(k) >= i_from) && (i_word[k] ? !empty_one : !empty_zero);
        end
    end

    // Lowest candidate wins
    always_comb begin
        pos = '0;
        for (int k = MESSAGE_BITS - 1; k >= 0; k--) begin
            if (cand[k]) begin
                pos = IDX_W'(k);
            end
        end
    end

    assign cur_bit = i_word[pos];
    assign marks   = cur_bit ? i_cfg.one_mark : i_cfg.zero_mark;

    assign o_found          = |cand;
    assign o_idx            = pos;
    assign o_phase.in_space = (marks == '0);
    assign o_phase.periods  = marks;
    assign o_phase.space    = cur_bit ? i_cfg.one_space : i_cfg.zero_space;

endmodule

`default_nettype wire
